// ===== rtl/tli_pkg.sv =====
// shared types and codes for the table linear interpolator
package tli_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned ST_W  = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [ST_W-1:0] ST_INTERP = 3'd0;
  localparam logic [ST_W-1:0] ST_BELOW  = 3'd1;
  localparam logic [ST_W-1:0] ST_ABOVE  = 3'd2;
  localparam logic [ST_W-1:0] ST_FAIL   = 3'd3;
  localparam logic [ST_W-1:0] ST_ZWIDTH = 3'd4;
  localparam logic [ST_W-1:0] ST_WACK   = 3'd5;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
  } tli_cmd_t;

endpackage

// ===== rtl/tli_ifs.sv =====
// input and result channel interfaces
interface tli_in_if #(parameter int VALUE_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [tli_pkg::IDX_W-1:0]      entry_index;
  logic signed [VALUE_WIDTH-1:0]  entry_x;
  logic signed [VALUE_WIDTH-1:0]  entry_y;
  logic signed [VALUE_WIDTH-1:0]  query_x;
  modport source (output valid, opcode, entry_index, entry_x, entry_y, query_x, input ready);
  modport sink (input valid, opcode, entry_index, entry_x, entry_y, query_x, output ready);
endinterface

interface tli_out_if #(parameter int VALUE_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_WIDTH-1:0]  interpolated_y;
  logic [tli_pkg::IDX_W-1:0]      segment_index;
  logic [tli_pkg::ST_W-1:0]       status;
  modport source (output valid, interpolated_y, segment_index, status, input ready);
  modport sink (input valid, interpolated_y, segment_index, status, output ready);
endinterface

// ===== rtl/tli_ram.sv =====
// generic single port ram with registered read
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/tli_fifo.sv =====
// small register queue between front and back
module tli_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r;
  logic [PW-1:0]    rptr_r;
  logic [CW-1:0]    count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/tli_front.sv =====
// front end: accepts words, clamps the point count and queues the command
module tli_front #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int FW = $bits(tli_pkg::tli_cmd_t) + AW + 3 * VALUE_WIDTH
) (
  tli_in_if.sink                        in_chan,
  input  logic [tli_pkg::CNT_W-1:0]     point_count,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [FW-1:0]                 q_data
);

  tli_pkg::tli_cmd_t cmd;
  logic [31:0]       pc32;
  logic [31:0]       n32;
  logic [AW-1:0]     last;

  always_comb begin
    pc32 = 32'(point_count);
    if (pc32 < 32'd2) begin
      n32 = 32'd2;
    end else if (pc32 > 32'(TABLE_DEPTH)) begin
      n32 = 32'(TABLE_DEPTH);
    end else begin
      n32 = pc32;
    end
    last    = AW'(n32 - 32'd1);
    cmd.op  = in_chan.opcode;
    cmd.idx = in_chan.entry_index;
  end

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;
  assign q_data        = {cmd, last, in_chan.entry_x, in_chan.entry_y, in_chan.query_x};

endmodule

// ===== rtl/tli_back.sv =====
// back end: table writes, end clamps, binary search and serial interpolation
module tli_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int FW = $bits(tli_pkg::tli_cmd_t) + AW + 3 * VALUE_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [FW-1:0] q_data,
  output logic          q_pop,
  tli_out_if.source     out_chan
);

  localparam int VW = VALUE_WIDTH;
  localparam int W  = VW + 1;
  localparam int CW = $clog2(2 * W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_CHK, S_P0, S_P1, S_P2, S_L0, S_L1, S_L2,
    S_PREP, S_MUL, S_DIV, S_FIN, S_EMIT
  } state_t;

  state_t                     state_r;
  tli_pkg::tli_cmd_t          h_cmd;
  logic [AW-1:0]              h_last;
  logic signed [VW-1:0]       h_x, h_y, h_q;

  logic [AW-1:0]              last_r, mid_r, seg_r;
  logic signed [AW:0]         lo_r, hi_r;
  logic signed [VW-1:0]       q_r, x0_r, x1_r, y0_r, y1_r, xm_r;
  logic [W-1:0]               dy_r, dx_r, r_r;
  logic [2*W-1:0]             p_r;
  logic                       neg_r;
  logic [CW-1:0]              cnt_r;
  logic signed [VW-1:0]       res_y_r;
  logic [tli_pkg::IDX_W-1:0]  res_seg_r;
  logic [tli_pkg::ST_W-1:0]   res_st_r;
  logic                       out_valid_r;
  logic signed [VW-1:0]       out_y_r;
  logic [tli_pkg::IDX_W-1:0]  out_seg_r;
  logic [tli_pkg::ST_W-1:0]   out_st_r;

  logic                       ram_en, ram_we;
  logic [AW-1:0]              ram_addr;
  logic signed [VW-1:0]       x_rd, y_rd;
  logic signed [AW+1:0]       mid_sum;
  logic [AW-1:0]              mid_c;
  logic signed [VW:0]         dy_s, dx_s, t_s;
  logic [W:0]                 mul_sum;
  logic [W:0]                 rem, rem_sub;
  logic                       ge;
  logic [W-1:0]               ysx, room;
  logic                       sat;
  logic signed [VW-1:0]       fin_y;
  logic                       emit;

  assign {h_cmd, h_last, h_x, h_y, h_q} = q_data;
  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign emit  = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = '0;
    mid_sum  = {lo_r[AW], lo_r} + {hi_r[AW], hi_r};
    mid_c    = mid_sum[AW:1];
    unique case (state_r)
      S_IDLE: begin
        ram_addr = AW'(32'(h_cmd.idx));
        if (q_pop && h_cmd.op == tli_pkg::OP_WRITE && 32'(h_cmd.idx) < 32'(TABLE_DEPTH)) begin
          ram_en = 1'b1;
          ram_we = 1'b1;
        end
      end
      S_RDA: begin
        ram_en = 1'b1;
      end
      S_RDB: begin
        ram_en   = 1'b1;
        ram_addr = last_r;
      end
      S_P0: begin
        ram_en   = 1'b1;
        ram_addr = mid_c;
      end
      S_P1: begin
        ram_en   = 1'b1;
        ram_addr = mid_r + AW'(1);
      end
      S_L0: begin
        ram_en   = 1'b1;
        ram_addr = seg_r;
      end
      S_L1: begin
        ram_en   = 1'b1;
        ram_addr = seg_r + AW'(1);
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  tli_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_x_ram (
    .clk, .en(ram_en), .we(ram_we), .addr(ram_addr), .wdata(h_x), .rdata(x_rd)
  );

  tli_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_y_ram (
    .clk, .en(ram_en), .we(ram_we), .addr(ram_addr), .wdata(h_y), .rdata(y_rd)
  );

  always_comb begin
    dy_s    = {y1_r[VW-1], y1_r} - {y0_r[VW-1], y0_r};
    dx_s    = {x1_r[VW-1], x1_r} - {x0_r[VW-1], x0_r};
    t_s     = {q_r[VW-1], q_r} - {x0_r[VW-1], x0_r};
    mul_sum = {1'b0, p_r[2*W-1:W]} + (p_r[0] ? {1'b0, dy_r} : '0);
    rem     = {r_r, p_r[2*W-1]};
    ge      = rem >= {1'b0, dx_r};
    rem_sub = rem - {1'b0, dx_r};
    ysx     = {y0_r[VW-1], y0_r};
    room    = neg_r ? (ysx - {2'b11, {(VW-1){1'b0}}}) : ({2'b00, {(VW-1){1'b1}}} - ysx);
    sat     = p_r > {{W{1'b0}}, room};
    if (sat) begin
      fin_y = neg_r ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else if (neg_r) begin
      fin_y = y0_r - p_r[VW-1:0];
    end else begin
      fin_y = y0_r + p_r[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (h_cmd.op == tli_pkg::OP_WRITE) begin
              res_y_r   <= '0;
              res_seg_r <= h_cmd.idx;
              res_st_r  <= tli_pkg::ST_WACK;
              state_r   <= S_EMIT;
            end else begin
              state_r <= S_RDA;
            end
          end
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          x0_r    <= x_rd;
          y0_r    <= y_rd;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (q_r <= x0_r) begin
            res_y_r   <= y0_r;
            res_seg_r <= '0;
            res_st_r  <= tli_pkg::ST_BELOW;
            state_r   <= S_EMIT;
          end else if (q_r >= x_rd) begin
            res_y_r   <= y_rd;
            res_seg_r <= tli_pkg::IDX_W'(32'(last_r));
            res_st_r  <= tli_pkg::ST_ABOVE;
            state_r   <= S_EMIT;
          end else begin
            lo_r    <= '0;
            hi_r    <= $signed({1'b0, last_r}) - (AW+1)'(1);
            state_r <= S_P0;
          end
        end
        S_P0: begin
          if (lo_r == hi_r) begin
            seg_r   <= lo_r[AW-1:0];
            state_r <= S_L0;
          end else if (lo_r > hi_r) begin
            res_y_r   <= '0;
            res_seg_r <= '0;
            res_st_r  <= tli_pkg::ST_FAIL;
            state_r   <= S_EMIT;
          end else begin
            mid_r   <= mid_c;
            state_r <= S_P1;
          end
        end
        S_P1: begin
          xm_r    <= x_rd;
          state_r <= S_P2;
        end
        S_P2: begin
          if (xm_r <= q_r && q_r < x_rd) begin
            seg_r   <= mid_r;
            state_r <= S_L0;
          end else begin
            if (q_r < xm_r) begin
              hi_r <= $signed({1'b0, mid_r}) - (AW+1)'(1);
            end else begin
              lo_r <= $signed({1'b0, mid_r}) + (AW+1)'(1);
            end
            state_r <= S_P0;
          end
        end
        S_L0: state_r <= S_L1;
        S_L1: begin
          x0_r    <= x_rd;
          y0_r    <= y_rd;
          state_r <= S_L2;
        end
        S_L2: begin
          x1_r    <= x_rd;
          y1_r    <= y_rd;
          state_r <= S_PREP;
        end
        S_PREP: begin
          res_seg_r <= tli_pkg::IDX_W'(32'(seg_r));
          if (x1_r == x0_r) begin
            res_y_r  <= y0_r;
            res_st_r <= tli_pkg::ST_ZWIDTH;
            state_r  <= S_EMIT;
          end else begin
            res_st_r <= tli_pkg::ST_INTERP;
            dy_r     <= dy_s[VW] ? W'(-dy_s) : W'(dy_s);
            dx_r     <= dx_s[VW] ? W'(-dx_s) : W'(dx_s);
            p_r      <= {{W{1'b0}}, (t_s[VW] ? W'(-t_s) : W'(t_s))};
            neg_r    <= dy_s[VW] ^ dx_s[VW] ^ t_s[VW];
            cnt_r    <= '0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          p_r   <= {mul_sum, p_r[W-1:1]};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(W - 1)) begin
            cnt_r   <= '0;
            r_r     <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          r_r   <= ge ? rem_sub[W-1:0] : rem[W-1:0];
          p_r   <= {p_r[2*W-2:0], ge};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(2 * W - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_y_r <= fin_y;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            out_y_r   <= res_y_r;
            out_seg_r <= res_seg_r;
            out_st_r  <= res_st_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (q_pop) begin
        q_r    <= h_q;
        last_r <= h_last;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.interpolated_y = out_y_r;
  assign out_chan.segment_index  = out_seg_r;
  assign out_chan.status         = out_st_r;

`ifndef NO_ASSERTIONS
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && h_cmd.op == tli_pkg::OP_WRITE) |=>
      (state_r == S_EMIT && res_st_r == tli_pkg::ST_WACK))
    else $error("write not acknowledged");
  a_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dx_r != '0))
    else $error("division by zero width");
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");
  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r < CW'(W)))
    else $error("multiply count overrun");
`endif

endmodule

// ===== rtl/table_linear_interpolator_unit.sv =====
// top level of the piecewise linear interpolation table
//
// in_chan carries words: opcode 0 writes entry_x/entry_y at entry_index,
// opcode 1 interpolates at query_x. out_chan returns one word per input word:
// interpolated_y, segment_index and status (write ack for writes).
// cfg_we/cfg_data set point_count, written by user only while idle; not enforced.
// a two-word queue sits between the accepting front and the working back,
// so in_chan.ready only drops when the queue is full.
// writes are acknowledged straight from idle; end clamps first read the
// first and last table entries. interpolated queries then run a binary
// search, in which each probe reads two table entries through the single
// ram port, then a shift-add multiply of VALUE_WIDTH+1 steps and a
// restoring divide of 2*(VALUE_WIDTH+1) steps.
// items are processed one at a time, in order.
// reset clears the queue and result valid and sets point_count to 2;
// table contents are undefined until written.
// when out_chan.ready is low the result holds and the back waits, while the
// queue keeps taking words until full.
module table_linear_interpolator_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tli_pkg::CNT_W-1:0]   cfg_data,
  tli_in_if.sink                      in_chan,
  tli_out_if.source                   out_chan
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = $bits(tli_pkg::tli_cmd_t) + AW + 3 * VALUE_WIDTH;

  logic [tli_pkg::CNT_W-1:0] point_count_r;
  logic                      q_push, q_pop, q_full, q_empty;
  logic [FW-1:0]             q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= tli_pkg::CNT_W'(2);
    end else if (cfg_we) begin
      point_count_r <= cfg_data;
    end
  end

  tli_front #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .in_chan, .point_count(point_count_r), .q_full, .q_push, .q_data(q_wdata)
  );

  tli_fifo #(.WIDTH(FW), .DEPTH(2)) u_fifo (
    .clk, .rst_n, .push(q_push), .push_data(q_wdata), .pop(q_pop),
    .pop_data(q_rdata), .full(q_full), .empty(q_empty)
  );

  tli_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_rdata), .q_pop, .out_chan
  );

endmodule
